[sv/afd_pkg.sv]
// ----------------------------------------------------------------------------
// afd_pkg
// Shared widths, codes, types and cell step functions for the array focusing
// delay block.
// ----------------------------------------------------------------------------
`default_nettype none

package afd_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int SPEED_WIDTH = 18;
  localparam int DELAY_WIDTH = 32;
  localparam int APB_WIDTH   = 32;
  localparam int ADDR_WIDTH  = 5;

  // square root datapath: radicand below 2^(2W), root fits W bits
  localparam int RAD_WIDTH   = 2 * COORD_WIDTH;
  localparam int ROOT_WIDTH  = COORD_WIDTH;
  localparam int REM_WIDTH   = COORD_WIDTH + 2;
  localparam int SQRT_STEPS  = ROOT_WIDTH;

  // edge path minus element path(s), and its magnitude
  localparam int DIFF_WIDTH  = COORD_WIDTH + 2;
  localparam int MAG_WIDTH   = COORD_WIDTH + 1;

  // delay = (mag * 32000 + ss) / (2 * ss), rounded half away from zero
  localparam int SCALE_WIDTH = 15;
  localparam logic [SCALE_WIDTH-1:0] SCALE = SCALE_WIDTH'(32000);
  localparam int NUM_WIDTH   = MAG_WIDTH + SCALE_WIDTH + 1;
  localparam int DIV_WIDTH   = SPEED_WIDTH + 1;
  localparam int DIV_STEPS   = NUM_WIDTH;

  localparam logic [SPEED_WIDTH-1:0] SPEED_RESET = SPEED_WIDTH'(23744);
  localparam logic [COORD_WIDTH-1:0] RAD_CAP = COORD_WIDTH'(3) << (COORD_WIDTH - 2);

  typedef enum logic [2:0] {
    MODE_NONE = 3'd0,
    MODE_X    = 3'd1,
    MODE_Y    = 3'd2,
    MODE_XY   = 3'd3,
    MODE_SUM  = 3'd4,
    MODE_USER = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_FOCAL  = 3'd1,
    REG_MAX_X  = 3'd2,
    REG_MAX_Y  = 3'd3,
    REG_RADIUS = 3'd4,
    REG_SPEED  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]                    mode;
    logic signed [COORD_WIDTH-1:0] focal;
    logic [COORD_WIDTH-2:0]        max_x;
    logic [COORD_WIDTH-2:0]        max_y;
    logic [COORD_WIDTH-1:0]        radius;
    logic [SPEED_WIDTH-1:0]        speed;
  } cfg_t;

  typedef struct packed {
    logic [RAD_WIDTH-1:0]  rad;
    logic [REM_WIDTH-1:0]  rem;
    logic [ROOT_WIDTH-1:0] root;
  } sqrt_t;

  // edge path, element path, second element path (x plus y mode)
  typedef struct packed {
    sqrt_t a;
    sqrt_t b;
    sqrt_t c;
  } sqrt3_t;

  typedef struct packed {
    logic [NUM_WIDTH-1:0] num;
    logic [DIV_WIDTH-1:0] rem;
    logic                 neg;
  } div_cell_t;

  function automatic logic [COORD_WIDTH-1:0] mag_of(logic [COORD_WIDTH-1:0] v);
    return v[COORD_WIDTH-1] ? (~v + COORD_WIDTH'(1)) : v;
  endfunction

  // one digit of the restoring square root
  function automatic sqrt_t sqrt_step(sqrt_t s);
    logic [REM_WIDTH+1:0] rem_sh;
    logic [REM_WIDTH+1:0] trial;
    logic [REM_WIDTH+1:0] dif;
    logic                 ge;
    sqrt_t                r;
    rem_sh = {s.rem, s.rad[RAD_WIDTH-1 -: 2]};
    trial  = {{(REM_WIDTH-ROOT_WIDTH){1'b0}}, s.root, 2'b01};
    ge     = (rem_sh >= trial);
    dif    = rem_sh - trial;
    r.rad  = {s.rad[RAD_WIDTH-3:0], 2'b00};
    r.rem  = ge ? dif[REM_WIDTH-1:0] : rem_sh[REM_WIDTH-1:0];
    r.root = {s.root[ROOT_WIDTH-2:0], ge};
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/afd_if.sv]
// ----------------------------------------------------------------------------
// afd_in_if / afd_out_if
// Valid/ready channels for element positions and focusing delays.
// ----------------------------------------------------------------------------
`default_nettype none

interface afd_in_if;
  import afd_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] elem_x;
  logic signed [COORD_WIDTH-1:0] elem_y;
  modport source (output valid, elem_x, elem_y, input ready);
  modport sink   (input valid, elem_x, elem_y, output ready);
endinterface

interface afd_out_if;
  import afd_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [DELAY_WIDTH-1:0] delay;
  logic                          delay_valid;
  modport source (output valid, delay, delay_valid, input ready);
  modport sink   (input valid, delay, delay_valid, output ready);
endinterface

`default_nettype wire

[sv/afd_prep.sv]
// ----------------------------------------------------------------------------
// afd_prep
// Front end: captures the element, picks operands per mode, squares them and
// forms the three radicands for the square root chain.
// ----------------------------------------------------------------------------
`default_nettype none

module afd_prep (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           vld_i,
  input  wire logic [afd_pkg::COORD_WIDTH-1:0] elem_x,
  input  wire logic [afd_pkg::COORD_WIDTH-1:0] elem_y,
  input  wire afd_pkg::cfg_t                  cfg,
  output logic                                vld_o,
  output afd_pkg::sqrt3_t                     rad_o
);
  import afd_pkg::*;

  logic                   v1_r, v2_r, v3_r, v4_r;
  logic [COORD_WIDTH-1:0] x_r, y_r;
  logic [COORD_WIDTH-1:0] op_a_r, op_b_r, ay_r, af_r;
  logic [COORD_WIDTH-1:0] op_a_nxt, op_b_nxt, ax, ay, rad_cl;
  logic [RAD_WIDTH-1:0]   sq_a_r, sq_b_r, sq_y_r, sq_f_r;
  logic [RAD_WIDTH-1:0]   rad_b_nxt;
  sqrt3_t                 rad_r;

  always_comb begin
    ax     = mag_of(x_r);
    ay     = mag_of(y_r);
    rad_cl = (cfg.radius > RAD_CAP) ? RAD_CAP : cfg.radius;
    case (cfg.mode)
      MODE_X:  op_a_nxt = {1'b0, cfg.max_x};
      MODE_Y:  op_a_nxt = {1'b0, cfg.max_y};
      default: op_a_nxt = rad_cl;
    endcase
    op_b_nxt = (cfg.mode == MODE_Y) ? ay : ax;
  end

  // element radial path also takes y squared
  assign rad_b_nxt = sq_b_r + sq_f_r + ((cfg.mode == MODE_XY) ? sq_y_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r       <= elem_x;
      y_r       <= elem_y;
      op_a_r    <= op_a_nxt;
      op_b_r    <= op_b_nxt;
      ay_r      <= ay;
      af_r      <= mag_of(cfg.focal);
      sq_a_r    <= RAD_WIDTH'(op_a_r) * RAD_WIDTH'(op_a_r);
      sq_b_r    <= RAD_WIDTH'(op_b_r) * RAD_WIDTH'(op_b_r);
      sq_y_r    <= RAD_WIDTH'(ay_r) * RAD_WIDTH'(ay_r);
      sq_f_r    <= RAD_WIDTH'(af_r) * RAD_WIDTH'(af_r);
      rad_r.a   <= '{rad: sq_a_r + sq_f_r, rem: '0, root: '0};
      rad_r.b   <= '{rad: rad_b_nxt, rem: '0, root: '0};
      rad_r.c   <= '{rad: sq_y_r + sq_f_r, rem: '0, root: '0};
    end
  end

  assign vld_o = v4_r;
  assign rad_o = rad_r;

endmodule

`default_nettype wire

[sv/afd_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// afd_sqrt_cell
// One root digit for three independent lanes; cells chain into a pipelined
// integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module afd_sqrt_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            vld_i,
  input  wire afd_pkg::sqrt3_t d_i,
  output logic                 vld_o,
  output afd_pkg::sqrt3_t      d_o
);
  import afd_pkg::*;

  logic   vld_r;
  sqrt3_t d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r.a <= sqrt_step(d_i.a);
      d_r.b <= sqrt_step(d_i.b);
      d_r.c <= sqrt_step(d_i.c);
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

`default_nettype wire

[sv/afd_div_cell.sv]
// ----------------------------------------------------------------------------
// afd_div_cell
// One quotient bit of a restoring divide; quotient bits shift into the low
// end of the numerator as it leaves the top.
// ----------------------------------------------------------------------------
`default_nettype none

module afd_div_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic [afd_pkg::DIV_WIDTH-1:0] dvs,
  input  wire logic                         vld_i,
  input  wire afd_pkg::div_cell_t           d_i,
  output logic                              vld_o,
  output afd_pkg::div_cell_t                d_o
);
  import afd_pkg::*;

  logic                 vld_r;
  div_cell_t            d_r;
  logic [DIV_WIDTH:0]   rem_sh, dif;
  logic                 ge;

  always_comb begin
    rem_sh = {d_i.rem, d_i.num[NUM_WIDTH-1]};
    ge     = (rem_sh >= {1'b0, dvs});
    dif    = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r.num <= {d_i.num[NUM_WIDTH-2:0], ge};
      d_r.rem <= ge ? dif[DIV_WIDTH-1:0] : rem_sh[DIV_WIDTH-1:0];
      d_r.neg <= d_i.neg;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

`default_nettype wire

[sv/array_focus_delay.sv]
// ----------------------------------------------------------------------------
// array_focus_delay
// Focusing delay per array element: squares, a 24-cell square root chain,
// path difference, scaling and a 41-cell divide chain, then saturation.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output skid register is empty;
// set by the square root and divide cell chains, each cell handling one
// digit of one item per cycle.
// Reset: synchronous, active low; clears all valid bits and loads the
// registers with their reset values (sound_speed 23744, others 0).
// ----------------------------------------------------------------------------
`default_nettype none

module array_focus_delay (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  afd_in_if.sink                              in_ch,
  afd_out_if.source                           out_ch,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [afd_pkg::ADDR_WIDTH-1:0] cfg_paddr,
  input  wire logic [afd_pkg::APB_WIDTH-1:0]  cfg_pwdata,
  output logic      [afd_pkg::APB_WIDTH-1:0]  cfg_prdata,
  output logic                                cfg_pready
);
  import afd_pkg::*;

  // ---------------- configuration registers ----------------
  cfg_t     cfg_r;
  reg_idx_t cfg_idx;
  logic     cfg_wr;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[ADDR_WIDTH-1:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mode: MODE_NONE, focal: '0, max_x: '0, max_y: '0, radius: '0,
                 speed: SPEED_RESET};
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:   cfg_r.mode   <= cfg_pwdata[2:0];
        REG_FOCAL:  cfg_r.focal  <= cfg_pwdata[COORD_WIDTH-1:0];
        REG_MAX_X:  cfg_r.max_x  <= cfg_pwdata[COORD_WIDTH-2:0];
        REG_MAX_Y:  cfg_r.max_y  <= cfg_pwdata[COORD_WIDTH-2:0];
        REG_RADIUS: cfg_r.radius <= cfg_pwdata[COORD_WIDTH-1:0];
        REG_SPEED:  cfg_r.speed  <= cfg_pwdata[SPEED_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:   cfg_prdata = APB_WIDTH'(cfg_r.mode);
      REG_FOCAL:  cfg_prdata = APB_WIDTH'($unsigned(cfg_r.focal));
      REG_MAX_X:  cfg_prdata = APB_WIDTH'(cfg_r.max_x);
      REG_MAX_Y:  cfg_prdata = APB_WIDTH'(cfg_r.max_y);
      REG_RADIUS: cfg_prdata = APB_WIDTH'(cfg_r.radius);
      REG_SPEED:  cfg_prdata = APB_WIDTH'(cfg_r.speed);
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline enable ----------------
  logic en;
  logic skid_vld_r;

  assign en          = ~skid_vld_r;
  assign in_ch.ready = en;

  // ---------------- front end ----------------
  logic   sq_vld [0:SQRT_STEPS];
  sqrt3_t sq_d   [0:SQRT_STEPS];

  afd_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_ch.valid),
    .elem_x (in_ch.elem_x),
    .elem_y (in_ch.elem_y),
    .cfg    (cfg_r),
    .vld_o  (sq_vld[0]),
    .rad_o  (sq_d[0])
  );

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    afd_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (sq_vld[i]),
      .d_i   (sq_d[i]),
      .vld_o (sq_vld[i+1]),
      .d_o   (sq_d[i+1])
    );
  end

  // ---------------- path difference and scaling ----------------
  logic [ROOT_WIDTH-1:0]  sub_c;
  logic [DIFF_WIDTH-1:0]  diff;
  logic [MAG_WIDTH-1:0]   mag_nxt, mag_r;
  logic                   neg_r, dif_vld_r, mul_vld_r;
  logic [SPEED_WIDTH-1:0] ss;
  div_cell_t              mul_r;

  assign ss    = (cfg_r.speed == '0) ? SPEED_WIDTH'(1) : cfg_r.speed;
  assign sub_c = (cfg_r.mode == MODE_SUM) ? sq_d[SQRT_STEPS].c.root : '0;

  always_comb begin
    diff = DIFF_WIDTH'(sq_d[SQRT_STEPS].a.root) - DIFF_WIDTH'(sq_d[SQRT_STEPS].b.root)
         - DIFF_WIDTH'(sub_c);
    mag_nxt = diff[DIFF_WIDTH-1] ? MAG_WIDTH'(~diff + DIFF_WIDTH'(1)) : MAG_WIDTH'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dif_vld_r <= 1'b0;
      mul_vld_r <= 1'b0;
    end else if (en) begin
      dif_vld_r <= sq_vld[SQRT_STEPS];
      mul_vld_r <= dif_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r     <= mag_nxt;
      neg_r     <= diff[DIFF_WIDTH-1];
      // rounding: add half the divisor, i.e. ss against 2*ss
      mul_r.num <= NUM_WIDTH'(mag_r) * NUM_WIDTH'(SCALE) + NUM_WIDTH'(ss);
      mul_r.rem <= '0;
      mul_r.neg <= neg_r;
    end
  end

  // ---------------- divide chain ----------------
  logic                 dv_vld [0:DIV_STEPS];
  div_cell_t            dv_d   [0:DIV_STEPS];
  logic [DIV_WIDTH-1:0] dvs;

  assign dvs       = {ss, 1'b0};
  assign dv_vld[0] = mul_vld_r;
  assign dv_d[0]   = mul_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    afd_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .dvs   (dvs),
      .vld_i (dv_vld[i]),
      .d_i   (dv_d[i]),
      .vld_o (dv_vld[i+1]),
      .d_o   (dv_d[i+1])
    );
  end

  // ---------------- saturation and mode select ----------------
  logic [NUM_WIDTH-1:0]   q;
  logic [DELAY_WIDTH-1:0] sat, res_delay;
  logic                   res_dv;

  assign q = dv_d[DIV_STEPS].num;

  always_comb begin
    if (!dv_d[DIV_STEPS].neg) begin
      sat = (q[NUM_WIDTH-1:DELAY_WIDTH-1] != '0) ? {1'b0, {(DELAY_WIDTH-1){1'b1}}}
                                                 : q[DELAY_WIDTH-1:0];
    end else if ((q[NUM_WIDTH-1:DELAY_WIDTH] != '0) ||
                 (q[DELAY_WIDTH-1] && (q[DELAY_WIDTH-2:0] != '0))) begin
      sat = {1'b1, {(DELAY_WIDTH-1){1'b0}}};
    end else begin
      sat = ~q[DELAY_WIDTH-1:0] + DELAY_WIDTH'(1);
    end
    case (cfg_r.mode) inside
      MODE_X, MODE_Y, MODE_XY, MODE_SUM: begin
        res_delay = sat;
        res_dv    = 1'b1;
      end
      MODE_USER: begin
        res_delay = DELAY_WIDTH'(cfg_r.focal);
        res_dv    = 1'b1;
      end
      default: begin
        res_delay = '0;
        res_dv    = 1'b0;
      end
    endcase
  end

  // ---------------- output register with skid ----------------
  logic                   out_vld_r, out_dv_r, skid_dv_r;
  logic [DELAY_WIDTH-1:0] out_delay_r, skid_delay_r;
  logic                   out_free;

  assign out_free = ~out_vld_r | out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r  <= skid_vld_r | dv_vld[DIV_STEPS];
      skid_vld_r <= 1'b0;
    end else if (en && dv_vld[DIV_STEPS]) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_delay_r <= skid_vld_r ? skid_delay_r : res_delay;
      out_dv_r    <= skid_vld_r ? skid_dv_r : res_dv;
    end else if (en) begin
      skid_delay_r <= res_delay;
      skid_dv_r    <= res_dv;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.delay       = out_delay_r;
  assign out_ch.delay_valid = out_dv_r;

endmodule

`default_nettype wire

[tb/sv/afd_delay_checker.sv]
// ----------------------------------------------------------------------------
// afd_delay_checker
// Watches the element and delay channels and the register port, predicts the
// focusing delay of every accepted element and compares it with the results.
// ----------------------------------------------------------------------------
`default_nettype none

module afd_delay_checker
  import afd_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_elem_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_elem_y,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic signed [DELAY_WIDTH-1:0] out_delay,
  input  wire logic                          out_delay_valid,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic                          cfg_pready,
  input  wire logic [ADDR_WIDTH-1:0]         cfg_paddr,
  input  wire logic [APB_WIDTH-1:0]          cfg_pwdata,
  output int                                 pending_delays,
  output int                                 mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [DELAY_WIDTH-1:0] delay;
    logic                          delay_valid;
  } focus_delay_t;

  focus_delay_t focus_delay_q[$];
  cfg_t         regs;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint path_len(longint unsigned a, longint unsigned b,
                                      longint unsigned c);
    return longint'(int_sqrt(a * a + b * b + c * c));
  endfunction

  // path difference in 1/1024 mm -> rounded, saturated delay in 1/1024 us
  function automatic logic signed [DELAY_WIDTH-1:0] diff_to_delay(longint diff);
    longint unsigned ss, m, q;
    ss = (regs.speed == 0) ? 1 : regs.speed;
    m  = (diff < 0) ? -diff : diff;
    q  = (m * 32000 + ss) / (2 * ss);
    if (diff >= 0) return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : DELAY_WIDTH'(q);
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return DELAY_WIDTH'(-longint'(q));
  endfunction

  function automatic focus_delay_t predict_delay(logic signed [COORD_WIDTH-1:0] ex,
                                                 logic signed [COORD_WIDTH-1:0] ey);
    longint       sx, sy, fs;
    longint unsigned ax, ay, af, rad, rcap;
    focus_delay_t res;
    sx   = ex;
    sy   = ey;
    fs   = regs.focal;
    ax   = (sx < 0) ? -sx : sx;
    ay   = (sy < 0) ? -sy : sy;
    af   = (fs < 0) ? -fs : fs;
    rcap = 64'd3 << (COORD_WIDTH - 2);
    rad  = (regs.radius > rcap) ? rcap : regs.radius;
    res.delay_valid = 1'b1;
    res.delay = '0;
    case (regs.mode)
      MODE_X: begin
        res.delay = diff_to_delay(path_len(regs.max_x, af, 0) - path_len(ax, af, 0));
      end
      MODE_Y: begin
        res.delay = diff_to_delay(path_len(regs.max_y, af, 0) - path_len(ay, af, 0));
      end
      MODE_XY: begin
        res.delay = diff_to_delay(path_len(rad, af, 0) - path_len(ax, ay, af));
      end
      MODE_SUM: begin
        res.delay = diff_to_delay(path_len(rad, af, 0) -
                                  (path_len(ax, af, 0) + path_len(ay, af, 0)));
      end
      MODE_USER: begin
        res.delay = DELAY_WIDTH'(fs);
      end
      default: begin
        res.delay_valid = 1'b0;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    focus_delay_t want;
    if (!rst_n) begin
      regs <= '{mode: 3'd0, focal: '0, max_x: '0, max_y: '0, radius: '0,
                speed: SPEED_RESET};
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_MODE:   regs.mode   <= cfg_pwdata[2:0];
          REG_FOCAL:  regs.focal  <= cfg_pwdata[COORD_WIDTH-1:0];
          REG_MAX_X:  regs.max_x  <= cfg_pwdata[COORD_WIDTH-2:0];
          REG_MAX_Y:  regs.max_y  <= cfg_pwdata[COORD_WIDTH-2:0];
          REG_RADIUS: regs.radius <= cfg_pwdata[COORD_WIDTH-1:0];
          REG_SPEED:  regs.speed  <= cfg_pwdata[SPEED_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) focus_delay_q.push_back(predict_delay(in_elem_x, in_elem_y));
      if (out_valid && out_ready) begin
        if (focus_delay_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected delay %0d valid %0b", $realtime, out_delay,
                     out_delay_valid);
          mismatches <= mismatches + 1;
        end else begin
          want = focus_delay_q.pop_front();
          if (want.delay !== out_delay || want.delay_valid !== out_delay_valid) begin
            if (mismatches < 10)
              $display("%0t: delay exp %0d valid %0b, got %0d valid %0b", $realtime,
                       want.delay, want.delay_valid, out_delay, out_delay_valid);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending_delays <= focus_delay_q.size();
  end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives element positions and register writes into array_focus_delay with
// random gaps and back-pressure; the checker predicts and compares delays.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import afd_pkg::*;

  localparam int DRAIN_CYCLES = 90;
  localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] cfg_paddr = '0;
  logic [APB_WIDTH-1:0]  cfg_pwdata = '0;
  logic [APB_WIDTH-1:0]  cfg_prdata;
  logic                  cfg_pready;
  int                    pending_delays, mismatches;
  int                    ready_hold = 0;

  afd_in_if  in_ch ();
  afd_out_if out_ch ();

  array_focus_delay u_dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  afd_delay_checker u_chk (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_elem_x(in_ch.elem_x), .in_elem_y(in_ch.elem_y),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_delay(out_ch.delay), .out_delay_valid(out_ch.delay_valid),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .pending_delays, .mismatches
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result back-pressure
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ch.ready && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= gap_len();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [APB_WIDTH-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_WIDTH'(idx) << 2;
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_delays != 0 || in_ch.valid) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(logic [2:0] mode, logic [COORD_WIDTH-1:0] focal,
                          logic [COORD_WIDTH-2:0] mx, logic [COORD_WIDTH-2:0] my,
                          logic [COORD_WIDTH-1:0] rad, logic [SPEED_WIDTH-1:0] ss);
    wait_idle();
    reg_write(REG_MODE, APB_WIDTH'(mode));
    reg_write(REG_FOCAL, APB_WIDTH'(focal));
    reg_write(REG_MAX_X, APB_WIDTH'(mx));
    reg_write(REG_MAX_Y, APB_WIDTH'(my));
    reg_write(REG_RADIUS, APB_WIDTH'(rad));
    reg_write(REG_SPEED, APB_WIDTH'(ss));
  endtask

  task automatic send_elem(logic signed [COORD_WIDTH-1:0] x,
                           logic signed [COORD_WIDTH-1:0] y);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.elem_x <= x;
    in_ch.elem_y <= y;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_corners();
    send_elem(C_MIN, C_MIN);
    send_elem(C_MAX, C_MAX);
    send_elem('0, -1);
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [COORD_WIDTH-1:0] pick_coord(int lim);
    if ($urandom_range(0, 4) != 0) return COORD_WIDTH'($urandom_range(0, 2 * lim) - lim);
    return COORD_WIDTH'($urandom());
  endfunction

  initial begin
    logic [2:0]             mode;
    logic [COORD_WIDTH-2:0] mx, my;
    logic [SPEED_WIDTH-1:0] ss;
    in_ch.valid  = 1'b0;
    in_ch.elem_x = '0;
    in_ch.elem_y = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset settings, each mode, extremes, zero and slow speed
    send_corners();
    set_regs(MODE_USER, C_MIN, '1, '1, '1, '1);
    send_corners();
    set_regs(MODE_X, C_MAX, '1, '0, '0, '0);
    send_corners();
    set_regs(MODE_Y, '0, '0, '1, '0, 18'd1);
    send_corners();
    set_regs(MODE_XY, '0, '1, '1, '1, SPEED_RESET);
    send_corners();
    set_regs(MODE_SUM, C_MIN, '1, '1, 24'd12582913, 18'd1);
    send_corners();
    set_regs(3'd6, 24'd100, 23'd100, 23'd100, 24'd141, SPEED_RESET);
    send_corners();
    set_regs(3'd7, 24'd100, 23'd100, 23'd100, 24'd141, SPEED_RESET);
    send_corners();

    for (int ph = 0; ph < 12; ph++) begin
      mode = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                         : 3'($urandom_range(MODE_X, MODE_USER));
      mx = ($urandom_range(0, 3) == 0) ? 23'($urandom()) : 23'($urandom_range(0, 65535));
      my = ($urandom_range(0, 3) == 0) ? 23'($urandom()) : 23'($urandom_range(0, 65535));
      ss = ($urandom_range(0, 3) == 0) ? 18'($urandom())
                                       : 18'($urandom_range(1400 * 16, 1600 * 16));
      set_regs(mode,
               ($urandom_range(0, 2) == 0) ? 24'($urandom())
                                           : 24'($urandom_range(0, 200000) - 100000),
               mx, my, 24'((longint'(mx) + my) * 3 / 4 + $urandom_range(0, 3)), ss);
      for (int i = 0; i < 111; i++) send_elem(pick_coord(mx), pick_coord(my));
      in_ch.valid <= 1'b0;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
sv/afd_pkg.sv
sv/afd_if.sv
sv/afd_prep.sv
sv/afd_sqrt_cell.sv
sv/afd_div_cell.sv
sv/array_focus_delay.sv
tb/sv/afd_delay_checker.sv
tb/sv/testbench.sv
